// ===== rtl/u8dec_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// u8dec_pkg
// Shared types and constants for the streaming UTF-8 validator and decoder.
// ----------------------------------------------------------------------------
package u8dec_pkg;

    localparam int CpWidth = 21;

    // Tag of a continuation byte, 10xxxxxx
    localparam logic [1:0] ContTag = 2'b10;

    // Decoder state carried from byte to byte
    typedef struct packed {
        logic [1:0]         pending;   // continuation bytes still expected
        logic [CpWidth-1:0] partial;   // code point bits gathered so far
        logic               clean;     // no error seen yet in this text
    } t_state;

    localparam t_state StateReset = '{pending: 2'd0, partial: '0, clean: 1'b1};

    // One result item
    typedef struct packed {
        logic [CpWidth-1:0] code_point;
        logic               char_ready;
        logic               bad_sequence;
        logic               text_done;
        logic               text_valid;
    } t_result;

endpackage : u8dec_pkg
`default_nettype wire

// ===== rtl/u8dec_step.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// u8dec_step
// Next-state and result logic for one byte of the UTF-8 stream.
// ----------------------------------------------------------------------------
module u8dec_step (
    input  wire u8dec_pkg::t_state  i_state,
    input  wire logic [7:0]         i_data_byte,
    input  wire logic               i_end_of_text,
    output u8dec_pkg::t_state       o_state,
    output u8dec_pkg::t_result      o_result,
    output logic                    o_has_result
);
    import u8dec_pkg::*;

    t_state             nxt;
    logic               ready;
    logic               bad;
    logic [CpWidth-1:0] cp;
    logic [CpWidth-1:0] cont_point;

    // Shift six payload bits of a continuation byte into the partial point
    assign cont_point = {i_state.partial[CpWidth-7:0], i_data_byte[5:0]};

    always_comb begin
        nxt   = i_state;
        ready = 1'b0;
        bad   = 1'b0;
        cp    = '0;

        if (i_state.pending == 2'd0) begin
            // Classify the lead byte
            case (i_data_byte) inside
                8'b0???????: begin
                    cp    = {{(CpWidth-8){1'b0}}, i_data_byte};
                    ready = 1'b1;
                end
                8'b110?????: begin
                    nxt.partial = {{(CpWidth-5){1'b0}}, i_data_byte[4:0]};
                    nxt.pending = 2'd1;
                end
                8'b1110????: begin
                    nxt.partial = {{(CpWidth-4){1'b0}}, i_data_byte[3:0]};
                    nxt.pending = 2'd2;
                end
                8'b11110???: begin
                    nxt.partial = {{(CpWidth-3){1'b0}}, i_data_byte[2:0]};
                    nxt.pending = 2'd3;
                end
                default: begin
                    bad = 1'b1;
                end
            endcase
        end else if (i_data_byte[7:6] == ContTag) begin
            // Gather a continuation byte; emit once the sequence closes
            nxt.partial = cont_point;
            nxt.pending = i_state.pending - 2'd1;
            if (i_state.pending == 2'd1) begin
                cp    = cont_point;
                ready = 1'b1;
            end
        end else begin
            bad = 1'b1;
        end

        // Drop the open sequence on an error
        if (bad) begin
            nxt.pending = 2'd0;
            nxt.partial = '0;
        end
        // Flag a text that ends inside a sequence
        if (i_end_of_text && (nxt.pending != 2'd0)) begin
            bad = 1'b1;
        end
        if (bad) begin
            nxt.clean = 1'b0;
        end

        o_result.code_point   = cp;
        o_result.char_ready   = ready;
        o_result.bad_sequence = bad;
        o_result.text_done    = i_end_of_text;
        o_result.text_valid   = i_end_of_text & nxt.clean;
        o_has_result          = ready | bad | i_end_of_text;

        // Start the next text from a clean state
        if (i_end_of_text) begin
            nxt = StateReset;
        end
        o_state = nxt;
    end

endmodule : u8dec_step
`default_nettype wire

// ===== rtl/utf8_stream_validate_decode.sv =====
`default_nettype none
// A result is registered and appears on the output in the cycle after the transfer.
// Throughput: one byte per cycle while the consumer does not stall; the state
// register closes a loop through the decode logic, and the output register holds
// a result while stalled. Bytes with no result clear valid, not the result fields.
// Reset (synchronous, active low) clears the decoder state and output valid.
// ----------------------------------------------------------------------------
// utf8_stream_validate_decode
// Streaming UTF-8 validator and decoder with per-text validity report.
// ----------------------------------------------------------------------------
module utf8_stream_validate_decode (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_valid,
    output logic                              o_stall,
    input  wire logic [7:0]                   i_data_byte,
    input  wire logic                         i_end_of_text,
    output logic                              o_valid,
    input  wire logic                         i_stall,
    output logic [u8dec_pkg::CpWidth-1:0]     o_code_point,
    output logic                              o_char_ready,
    output logic                              o_bad_sequence,
    output logic                              o_text_done,
    output logic                              o_text_valid
);
    import u8dec_pkg::*;

    t_state  r_state;
    t_state  n_state;
    t_result r_result;
    t_result n_result;
    logic    r_out_valid;
    logic    has_result;
    logic    in_xfer;
    logic    out_xfer;

    u8dec_step u_step (
        .i_state       (r_state),
        .i_data_byte   (i_data_byte),
        .i_end_of_text (i_end_of_text),
        .o_state       (n_state),
        .o_result      (n_result),
        .o_has_result  (has_result)
    );

    // Hold input while a result waits and the consumer stalls
    assign o_stall  = r_out_valid & i_stall;
    assign in_xfer  = i_valid & ~o_stall;
    assign out_xfer = r_out_valid & ~i_stall;

    // Advance decoder state on each input transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= StateReset;
        end else if (in_xfer) begin
            r_state <= n_state;
        end
    end

    // Load the output register; hold it while stalled
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_xfer) begin
            r_out_valid <= has_result;
        end else if (out_xfer) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer && has_result) begin
            r_result <= n_result;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_code_point   = r_result.code_point;
    assign o_char_ready   = r_result.char_ready;
    assign o_bad_sequence = r_result.bad_sequence;
    assign o_text_done    = r_result.text_done;
    assign o_text_valid   = r_result.text_valid;

    // A result is never both a character and an error
    a_ready_xor_bad : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !(r_result.char_ready && r_result.bad_sequence))
        else $error("char_ready and bad_sequence both set");

    // Code point is zero unless a character is ready
    a_cp_zero : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_result.char_ready) |-> (r_result.code_point == '0))
        else $error("nonzero code point without char_ready");

    // Text validity is only reported at the end of a text
    a_valid_at_done : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_result.text_valid) |-> r_result.text_done)
        else $error("text_valid without text_done");

    // State returns to clean, with a result valid, after the final byte of a text
    a_text_restart : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_xfer && i_end_of_text) |=>
            (r_state.pending == 2'd0 && r_state.clean && r_out_valid))
        else $error("state not restarted after end of text");

endmodule : utf8_stream_validate_decode
`default_nettype wire
